// File: hdl/wsu_pkg.sv
package wsu_pkg;

	localparam int BUCKETS  = 1024;
	localparam int CELLS    = 8;
	localparam int COUNTERS = 4;
	localparam int KEY_BITS = 64;

	localparam int BKT_W    = $clog2(BUCKETS);
	localparam int CELL_W   = $clog2(CELLS);
	localparam int CTR_W    = $clog2(COUNTERS);
	localparam int MAG_W    = 31;
	localparam int CNT_W    = 32;
	localparam int FACTOR_W = 12;
	localparam int THR_W    = MAG_W + FACTOR_W - 8;
	localparam int ACT_W    = 3;

	localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(256);
	localparam logic [MAG_W-1:0]    MAG_MAX      = {MAG_W{1'b1}};

	typedef enum logic [ACT_W-1:0] {
		ACT_CLEAN_HIT = 3'd0,
		ACT_ERROR_HIT = 3'd1,
		ACT_FILLED    = 3'd2,
		ACT_CNT_ONLY  = 3'd3,
		ACT_REPLACED  = 3'd4,
		ACT_READOUT   = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_PREP,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic                err;
		logic [MAG_W-1:0]    mag;
		logic [CTR_W-1:0]    cp;
		logic                sb;
	} cell_t;

	typedef cell_t [CELLS-1:0] cell_row_t;
	typedef logic [COUNTERS-1:0][CNT_W-1:0] ctr_row_t;

	// Count increment that sticks at the largest magnitude.
	function automatic logic [MAG_W-1:0] mag_inc(input logic [MAG_W-1:0] m);
		return (m == MAG_MAX) ? m : m + MAG_W'(1);
	endfunction

	// Clamp a 34-bit signed sum to the 32-bit signed range.
	function automatic logic [CNT_W-1:0] sat32(input logic signed [CNT_W+1:0] s);
		logic signed [CNT_W+1:0] hi;
		logic signed [CNT_W+1:0] lo;
		hi = (CNT_W+2)'(34'sd2147483647);
		lo = -(CNT_W+2)'(34'sd2147483648);
		if (s > hi)
			return {1'b0, {(CNT_W-1){1'b1}}};
		else if (s < lo)
			return {1'b1, {(CNT_W-1){1'b0}}};
		else
			return s[CNT_W-1:0];
	endfunction

endpackage

// File: hdl/wsu_if.sv
interface wsu_in_if;
	logic                           valid;
	logic                           ready;
	logic                           mode;
	logic [wsu_pkg::KEY_BITS-1:0]   key;
	logic [wsu_pkg::BKT_W-1:0]      bucket_index;
	logic [wsu_pkg::CTR_W-1:0]      counter_index;
	logic                           sign_bit;
	logic [wsu_pkg::CELL_W-1:0]     cell_index;

	modport source (output valid, mode, key, bucket_index, counter_index, sign_bit,
		cell_index, input ready);
	modport sink (input valid, mode, key, bucket_index, counter_index, sign_bit,
		cell_index, output ready);
endinterface

interface wsu_out_if;
	logic                           valid;
	logic                           ready;
	logic [wsu_pkg::ACT_W-1:0]      action;
	logic [wsu_pkg::KEY_BITS-1:0]   cell_key;
	logic [wsu_pkg::MAG_W-1:0]      cell_count;
	logic                           error_flag;
	logic signed [wsu_pkg::CNT_W-1:0] counter_value;

	modport source (output valid, action, cell_key, cell_count, error_flag,
		counter_value, input ready);
	modport sink (input valid, action, cell_key, cell_count, error_flag,
		counter_value, output ready);
endinterface

// File: hdl/waving_sketch_update_core.sv
// Waving sketch update core. Each bucket is one row of the cell memory (eight cells of key,
// error flag, 31-bit count and the key's counter hash) and one row of the counter memory (four
// signed 32-bit waving counters). An insert item reads both rows, scans the cells in parallel
// for a match or an empty cell, and otherwise waves the selected counter and may evict the
// smallest cell (a match on a flagged cell waves it too); a read item returns one cell and one
// counter. Every item gives exactly one result item. An item passes through accept and row
// read, scan, threshold multiply and counter add, and commit and write-back, which waits while
// the previous result has not been taken. The next item is accepted no earlier than the cycle
// after the commit, as set by the single read-modify-write of the bucket row, which also rules
// out any overlap on the same bucket. After reset the core clears both memories, one row per
// cycle, and accepts no item during that pass; the replacement factor may be written only
// while no item is in flight, since the threshold stage reads it directly.
module waving_sketch_update_core (
	input  logic                          clk,
	input  logic                          arst_n,
	wsu_in_if.sink                        item_in,
	wsu_out_if.source                     result_out,
	input  logic                          cfg_we,
	input  logic [wsu_pkg::FACTOR_W-1:0]  cfg_wdata
);

	// Configuration register.
	logic [wsu_pkg::FACTOR_W-1:0] factor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= wsu_pkg::FACTOR_RESET;
		end else if (cfg_we) begin
			factor_q <= cfg_wdata;
		end
	end

	// Control state.
	wsu_pkg::state_t             state_q, state_d;
	logic [wsu_pkg::BKT_W-1:0]   clr_addr_q;
	logic                        commit;
	logic                        mem_we;
	logic [wsu_pkg::BKT_W-1:0]   mem_waddr;
	logic                        accept;

	assign accept = item_in.valid && item_in.ready;

	// The item captured at acceptance stays put until its commit.
	logic                          mode_s1;
	logic [wsu_pkg::KEY_BITS-1:0]  key_s1;
	logic [wsu_pkg::BKT_W-1:0]     bkt_s1;
	logic [wsu_pkg::CTR_W-1:0]     cp_s1;
	logic                          sb_s1;
	logic [wsu_pkg::CELL_W-1:0]    cidx_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= item_in.mode;
			key_s1  <= item_in.key;
			bkt_s1  <= item_in.bucket_index;
			cp_s1   <= item_in.counter_index;
			sb_s1   <= item_in.sign_bit;
			cidx_s1 <= item_in.cell_index;
		end
	end

	// Bucket memories. The read data register is loaded only on acceptance, so it holds the
	// rows for the whole life of the item.
	wsu_pkg::cell_row_t cell_mem [wsu_pkg::BUCKETS];
	wsu_pkg::ctr_row_t  ctr_mem  [wsu_pkg::BUCKETS];
	wsu_pkg::cell_row_t cell_rd_q;
	wsu_pkg::ctr_row_t  ctr_rd_q;
	wsu_pkg::cell_row_t cell_wdata;
	wsu_pkg::ctr_row_t  ctr_wdata;
	wsu_pkg::cell_row_t cell_new;
	wsu_pkg::ctr_row_t  ctr_new;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem[mem_waddr] <= cell_wdata;
			ctr_mem[mem_waddr]  <= ctr_wdata;
		end
		if (accept) begin
			cell_rd_q <= cell_mem[item_in.bucket_index];
			ctr_rd_q  <= ctr_mem[item_in.bucket_index];
		end
	end

	// The clearing pass writes all-zero rows; everything else writes the updated rows back.
	assign cell_wdata = (state_q == wsu_pkg::ST_CLEAR) ? '0 : cell_new;
	assign ctr_wdata  = (state_q == wsu_pkg::ST_CLEAR) ? '0 : ctr_new;

	// Scan stage: first matching or empty cell, and the first cell of smallest count.
	logic                        scan_done;
	logic                        scan_hit;
	logic [wsu_pkg::CELL_W-1:0]  scan_pos;
	logic [wsu_pkg::MAG_W-1:0]   scan_min;
	logic [wsu_pkg::CELL_W-1:0]  scan_min_pos;

	always_comb begin
		scan_done    = 1'b0;
		scan_hit     = 1'b0;
		scan_pos     = '0;
		scan_min     = cell_rd_q[0].mag;
		scan_min_pos = '0;
		for (int i = 0; i < wsu_pkg::CELLS; i++) begin
			if (!scan_done) begin
				if (cell_rd_q[i].mag != '0 && cell_rd_q[i].key == key_s1) begin
					scan_done = 1'b1;
					scan_hit  = 1'b1;
					scan_pos  = wsu_pkg::CELL_W'(i);
				end else if (cell_rd_q[i].mag == '0) begin
					scan_done = 1'b1;
					scan_pos  = wsu_pkg::CELL_W'(i);
				end
			end
			if (cell_rd_q[i].mag < scan_min) begin
				scan_min     = cell_rd_q[i].mag;
				scan_min_pos = wsu_pkg::CELL_W'(i);
			end
		end
	end

	logic                        done_s2;
	logic                        hit_s2;
	logic [wsu_pkg::CELL_W-1:0]  pos_s2;
	logic [wsu_pkg::MAG_W-1:0]   min_mag_s2;
	logic [wsu_pkg::CELL_W-1:0]  min_pos_s2;

	always_ff @(posedge clk) begin
		if (state_q == wsu_pkg::ST_SCAN) begin
			done_s2    <= scan_done;
			hit_s2     <= scan_hit;
			pos_s2     <= scan_pos;
			min_mag_s2 <= scan_min;
			min_pos_s2 <= scan_min_pos;
		end
	end

	// Prepare stage: waved counter value and the eviction threshold.
	logic signed [wsu_pkg::CNT_W+1:0]         wave_sum;
	logic [wsu_pkg::MAG_W+wsu_pkg::FACTOR_W-1:0] thr_prod;
	logic [wsu_pkg::CNT_W-1:0]                cv_s3;
	logic [wsu_pkg::THR_W-1:0]                thr_s3;

	assign wave_sum = $signed({{2{ctr_rd_q[cp_s1][wsu_pkg::CNT_W-1]}}, ctr_rd_q[cp_s1]})
		+ (sb_s1 ? -(wsu_pkg::CNT_W+2)'(1) : (wsu_pkg::CNT_W+2)'(1));
	assign thr_prod = (wsu_pkg::MAG_W+wsu_pkg::FACTOR_W)'(min_mag_s2)
		* (wsu_pkg::MAG_W+wsu_pkg::FACTOR_W)'(factor_q);

	always_ff @(posedge clk) begin
		if (state_q == wsu_pkg::ST_PREP) begin
			cv_s3  <= wsu_pkg::sat32(wave_sum);
			thr_s3 <= thr_prod[wsu_pkg::MAG_W+wsu_pkg::FACTOR_W-1:8];
		end
	end

	// Commit stage: decide the case and build the rows to write back.
	logic signed [wsu_pkg::CNT_W:0]    est;
	logic signed [wsu_pkg::THR_W:0]    est_x;
	logic signed [wsu_pkg::THR_W:0]    thr_x;
	logic                              is_insert;
	logic                              replace;
	logic                              err_hit;
	logic                              full;
	wsu_pkg::cell_t                    hit_cell;
	wsu_pkg::cell_t                    victim;
	wsu_pkg::cell_t                    read_cell;
	logic [wsu_pkg::MAG_W-1:0]         hit_mag;
	logic [wsu_pkg::MAG_W-1:0]         repl_mag;
	logic [wsu_pkg::CNT_W-1:0]         flush_base;
	logic signed [wsu_pkg::CNT_W+1:0]  flush_sum;
	logic [wsu_pkg::MAG_W+2:0]         vmag_x;

	assign is_insert = !mode_s1;
	assign est   = sb_s1 ? -$signed({cv_s3[wsu_pkg::CNT_W-1], cv_s3})
	                     :  $signed({cv_s3[wsu_pkg::CNT_W-1], cv_s3});
	assign est_x = (wsu_pkg::THR_W+1)'(est);
	assign thr_x = $signed({1'b0, thr_s3});
	assign full    = is_insert && !done_s2;
	assign replace = full && (est_x >= thr_x);
	assign hit_cell  = cell_rd_q[pos_s2];
	assign victim    = cell_rd_q[min_pos_s2];
	assign read_cell = cell_rd_q[cidx_s1];
	assign err_hit   = is_insert && done_s2 && hit_s2 && hit_cell.err;
	assign hit_mag   = wsu_pkg::mag_inc(hit_cell.mag);
	assign repl_mag  = wsu_pkg::mag_inc(min_mag_s2);
	assign vmag_x    = (wsu_pkg::MAG_W+3)'(victim.mag);

	always_comb begin
		ctr_new    = ctr_rd_q;
		flush_base = '0;
		flush_sum  = '0;
		if (err_hit || full) begin
			ctr_new[cp_s1] = cv_s3;
		end
		// A clean victim hands its count back to its own counter, after the wave above.
		if (replace && !victim.err) begin
			flush_base = ctr_new[victim.cp];
			flush_sum  = $signed({{2{flush_base[wsu_pkg::CNT_W-1]}}, flush_base})
				+ (victim.sb ? -$signed(vmag_x) : $signed(vmag_x));
			ctr_new[victim.cp] = wsu_pkg::sat32(flush_sum);
		end
	end

	always_comb begin
		cell_new = cell_rd_q;
		if (is_insert && done_s2 && hit_s2) begin
			cell_new[pos_s2].mag = hit_mag;
		end else if (is_insert && done_s2) begin
			cell_new[pos_s2].key = key_s1;
			cell_new[pos_s2].err = 1'b0;
			cell_new[pos_s2].mag = wsu_pkg::MAG_W'(1);
			cell_new[pos_s2].cp  = cp_s1;
			cell_new[pos_s2].sb  = sb_s1;
		end else if (replace) begin
			cell_new[min_pos_s2].key = key_s1;
			cell_new[min_pos_s2].err = 1'b1;
			cell_new[min_pos_s2].mag = repl_mag;
			cell_new[min_pos_s2].cp  = cp_s1;
			cell_new[min_pos_s2].sb  = sb_s1;
		end
	end

	// Result fields of the committing item.
	wsu_pkg::action_t               res_action;
	logic [wsu_pkg::KEY_BITS-1:0]   res_key;
	logic [wsu_pkg::MAG_W-1:0]      res_count;
	logic                           res_err;

	always_comb begin
		if (mode_s1) begin
			res_action = wsu_pkg::ACT_READOUT;
			res_count  = read_cell.mag;
			res_key    = (read_cell.mag != '0) ? read_cell.key : '0;
			res_err    = (read_cell.mag != '0) ? read_cell.err : 1'b0;
		end else if (done_s2 && hit_s2) begin
			res_action = hit_cell.err ? wsu_pkg::ACT_ERROR_HIT : wsu_pkg::ACT_CLEAN_HIT;
			res_key    = key_s1;
			res_count  = hit_mag;
			res_err    = hit_cell.err;
		end else if (done_s2) begin
			res_action = wsu_pkg::ACT_FILLED;
			res_key    = key_s1;
			res_count  = wsu_pkg::MAG_W'(1);
			res_err    = 1'b0;
		end else if (replace) begin
			res_action = wsu_pkg::ACT_REPLACED;
			res_key    = key_s1;
			res_count  = repl_mag;
			res_err    = 1'b1;
		end else begin
			res_action = wsu_pkg::ACT_CNT_ONLY;
			res_key    = '0;
			res_count  = '0;
			res_err    = 1'b0;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= wsu_pkg::ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == wsu_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + wsu_pkg::BKT_W'(1);
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		item_in.ready = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = bkt_s1;
		commit        = 1'b0;
		unique case (state_q)
			wsu_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				if (clr_addr_q == wsu_pkg::BKT_W'(wsu_pkg::BUCKETS - 1)) begin
					state_d = wsu_pkg::ST_IDLE;
				end
			end
			wsu_pkg::ST_IDLE: begin
				item_in.ready = 1'b1;
				if (item_in.valid) begin
					state_d = wsu_pkg::ST_SCAN;
				end
			end
			wsu_pkg::ST_SCAN: begin
				state_d = wsu_pkg::ST_PREP;
			end
			wsu_pkg::ST_PREP: begin
				state_d = wsu_pkg::ST_COMMIT;
			end
			wsu_pkg::ST_COMMIT: begin
				// Wait here only while the previous result has not been taken.
				if (!result_out.valid || result_out.ready) begin
					commit  = 1'b1;
					mem_we  = is_insert;
					state_d = wsu_pkg::ST_IDLE;
				end
			end
		endcase
	end

	// Output register.
	logic                           out_valid_q;
	logic [wsu_pkg::ACT_W-1:0]      out_action_q;
	logic [wsu_pkg::KEY_BITS-1:0]   out_key_q;
	logic [wsu_pkg::MAG_W-1:0]      out_count_q;
	logic                           out_err_q;
	logic [wsu_pkg::CNT_W-1:0]      out_ctr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_action_q <= res_action;
			out_key_q    <= res_key;
			out_count_q  <= res_count;
			out_err_q    <= res_err;
			out_ctr_q    <= ctr_new[cp_s1];
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.action        = out_action_q;
	assign result_out.cell_key      = out_key_q;
	assign result_out.cell_count    = out_count_q;
	assign result_out.error_flag    = out_err_q;
	assign result_out.counter_value = $signed(out_ctr_q);

endmodule

// File: hdl/wsu_checker.sv
module wsu_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [wsu_pkg::ACT_W-1:0]     action,
	input logic [wsu_pkg::KEY_BITS-1:0]  cell_key,
	input logic [wsu_pkg::MAG_W-1:0]     cell_count,
	input logic                          error_flag
);

	// One item at a time: an accepted item closes the input until it commits.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted again while an item is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) && $stable(cell_count))
		else $error("stalled result changed");

	a_cnt_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == wsu_pkg::ACT_CNT_ONLY
		|-> cell_key == '0 && cell_count == '0 && !error_flag)
		else $error("counter-only result carries cell fields");

	a_filled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == wsu_pkg::ACT_FILLED |-> cell_count == 1 && !error_flag)
		else $error("filled cell is not a clean count of one");

	a_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == wsu_pkg::ACT_REPLACED || action == wsu_pkg::ACT_ERROR_HIT)
		|-> error_flag && cell_count >= 2)
		else $error("flagged result with wrong flag or count");

endmodule

bind waving_sketch_update_core wsu_checker u_wsu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item_in.valid),
	.in_ready   (item_in.ready),
	.out_valid  (result_out.valid),
	.out_ready  (result_out.ready),
	.action     (result_out.action),
	.cell_key   (result_out.cell_key),
	.cell_count (result_out.cell_count),
	.error_flag (result_out.error_flag)
);
